// File: sv/nhfs_pkg.sv
// Package for the NMEA header field splitter: controller state type, the
// match unit control word type and shared constants. No dependencies.
`default_nettype none

package nhfs_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int WINDOW_DEF       = 16;
    localparam int HDR_MAX_LEN      = 8;

    localparam logic [7:0] COMMA_CHAR = 8'h2C;

    localparam logic [1:0] CFG_HDR_CHARS = 2'd0;
    localparam logic [1:0] CFG_HDR_LEN   = 2'd1;
    localparam logic [1:0] CFG_FIELD_CNT = 2'd2;

    localparam logic [63:0] HDR_CHARS_RST = 64'd0;
    localparam logic [3:0]  HDR_LEN_RST   = 4'd6;
    localparam logic [5:0]  FIELD_CNT_RST = 6'd12;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OVF,
        S_SRCH,
        S_SCAN,
        S_CHECK,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    typedef struct packed {
        logic shift;
        logic cnt_ok;
    } t_match_ctl;

endpackage

`default_nettype wire

// File: sv/nhfs_buf.sv
// Sentence buffer: circular byte memory addressed by a logical index plus
// a base offset, one write and one registered read per cycle. Uses nhfs_pkg.
`default_nettype none

module nhfs_buf
    import nhfs_pkg::*;
#(
    parameter int DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic [$clog2(DEPTH)-1:0] i_base,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_idx,
    input  wire logic [7:0]               i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_idx,
    output logic      [7:0]               o_rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic [AW:0]   wr_sum;
    logic [AW:0]   rd_sum;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign wr_sum  = {1'b0, i_base} + {1'b0, i_wr_idx};
    assign rd_sum  = {1'b0, i_base} + {1'b0, i_rd_idx};
    assign wr_addr = (wr_sum >= (AW+1)'(DEPTH)) ? AW'(wr_sum - (AW+1)'(DEPTH)) : AW'(wr_sum);
    assign rd_addr = (rd_sum >= (AW+1)'(DEPTH)) ? AW'(rd_sum - (AW+1)'(DEPTH)) : AW'(rd_sum);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: sv/nhfs_match.sv
// Header match unit: a window of the most recent buffer bytes compared
// against the configured header, one buffer byte per shift. Uses nhfs_pkg.
`default_nettype none

module nhfs_match
    import nhfs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_match_ctl  i_ctl,
    input  wire logic [7:0]  i_data,
    input  wire logic [63:0] i_hdr_chars,
    input  wire logic [3:0]  i_hdr_len,
    output logic             o_hit
);

    logic [7:0] r_win [HDR_MAX_LEN-1];
    logic [7:0] win_cur [HDR_MAX_LEN];
    logic       hit;

    always_comb begin
        win_cur[0] = i_data;
        for (int k = 1; k < HDR_MAX_LEN; k++) begin
            win_cur[k] = r_win[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_win[0] <= i_data;
            for (int k = 1; k < HDR_MAX_LEN - 1; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    // Header character j sits len-1-j places behind the newest byte.
    always_comb begin
        logic [2:0] sel;
        sel = 3'd0;
        hit = i_ctl.cnt_ok;
        for (int j = 0; j < HDR_MAX_LEN; j++) begin
            if (4'(j) < i_hdr_len) begin
                sel = 3'(i_hdr_len - 4'(j) - 4'd1);
                if (i_hdr_chars[8*j +: 8] != win_cur[sel]) begin
                    hit = 1'b0;
                end
            end
        end
    end

    assign o_hit = hit && i_ctl.shift;

endmodule

`default_nettype wire

// File: sv/nmea_header_field_splitter_core.sv
// Top level of the NMEA header field splitter: controller, configuration
// registers and output register. Uses nhfs_pkg, nhfs_buf and nhfs_match.
//
//   Channel  | Handshake                  | Word
//   ---------+----------------------------+------------------------------------------
//   input    | i_in_valid / o_in_ready    | i_rx_byte
//   output   | o_out_valid / i_out_ready  | o_char_out, o_field_index, o_field_end,
//            |                            | o_last, o_overflow
//   config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Once the header is seen, each byte is appended and checked in S_CHECK. On reaching
// the search window, the controller issues one buffer read per cycle, first for the
// header search, then for the comma count of the kept bytes. Emitting a sentence reads
// each byte through the single buffer read port (S_EMIT_RD, then S_EMIT_OUT) and waits
// on output stalls. Reset clears control state and restores the configuration registers; no buffer clearing pass.
`default_nettype none

module nmea_header_field_splitter_core
    import nhfs_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    parameter int WINDOW       = WINDOW_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [7:0]  o_char_out,
    output logic      [5:0]  o_field_index,
    output logic             o_field_end,
    output logic             o_last,
    output logic             o_overflow,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int FW = $clog2(BUFFER_DEPTH + 1);

    t_state        r_state, n_state;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_seen, n_seen;
    logic [AW-1:0] r_base, n_base;
    logic [FW-1:0] r_idx, n_idx;
    logic          r_pv, n_pv;
    logic [AW-1:0] r_pidx, n_pidx;
    logic [FW-1:0] r_commas, n_commas;
    logic [AW-1:0] r_lastc, n_lastc;
    logic [5:0]    r_field, n_field;

    logic [63:0]   r_hdr_chars;
    logic [3:0]    r_hdr_len;
    logic [5:0]    r_field_cnt;

    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_char_out, n_char_out;
    logic [5:0]    r_field_index, n_field_index;
    logic          r_field_end, n_field_end;
    logic          r_last, n_last;
    logic          r_overflow, n_overflow;

    logic          acc_in;
    logic          full;
    logic [FW-1:0] fill_inc;
    logic          slot_free;
    logic          issue;
    logic          stream_end;
    logic [3:0]    len_eff;
    logic [FW-1:0] pidx_inc;
    logic [AW-1:0] pos;
    logic          hit;
    logic [7:0]    rd_data;
    logic          rd_comma;
    logic          rd_en;
    logic          wr_en;
    logic          emit_go;
    logic          at_last;
    logic          below_window;
    t_match_ctl    match_ctl;

    assign acc_in       = i_in_valid && o_in_ready;
    assign full         = (r_fill == FW'(BUFFER_DEPTH));
    assign fill_inc     = r_fill + FW'(1);
    assign below_window = (int'(fill_inc) < WINDOW);
    assign slot_free    = !r_out_valid || i_out_ready;
    assign issue        = (r_idx < r_fill);
    assign stream_end   = !r_pv && !issue;
    assign len_eff      = (r_hdr_len > 4'd8) ? 4'd8 : r_hdr_len;
    assign pidx_inc     = FW'(r_pidx) + FW'(1);
    assign pos          = AW'(pidx_inc - FW'(len_eff));
    assign rd_comma     = (rd_data == COMMA_CHAR);
    assign emit_go      = ({1'b0, r_field_cnt} <= 7'(r_commas));
    assign at_last      = (r_idx[AW-1:0] == r_lastc);

    assign wr_en = acc_in && !full;
    assign rd_en = (((r_state == S_SRCH) || (r_state == S_SCAN)) && issue)
                   || (r_state == S_EMIT_RD);

    assign match_ctl = '{shift:  (r_state == S_SRCH) && r_pv,
                         cnt_ok: (pidx_inc >= FW'(len_eff))};

    nhfs_buf #(
        .DEPTH(BUFFER_DEPTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_base    (r_base),
        .i_wr_en   (wr_en),
        .i_wr_idx  (r_fill[AW-1:0]),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_idx  (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    nhfs_match u_match (
        .i_clk       (i_clk),
        .i_ctl       (match_ctl),
        .i_data      (rd_data),
        .i_hdr_chars (r_hdr_chars),
        .i_hdr_len   (len_eff),
        .o_hit       (hit)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    if (full) begin
                        n_state = S_OVF;
                    end else if (r_seen) begin
                        n_state = S_CHECK;
                    end else if (!below_window) begin
                        n_state = (len_eff == 4'd0) ? S_SCAN : S_SRCH;
                    end
                end
            end
            S_OVF: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SRCH: begin
                if (hit) begin
                    n_state = S_SCAN;
                end else if (stream_end) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (stream_end) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (emit_go && (r_commas != '0)) begin
                    n_state = S_EMIT_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (slot_free) begin
                    n_state = at_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_fill        = r_fill;
        n_seen        = r_seen;
        n_base        = r_base;
        n_idx         = r_idx;
        n_pv          = r_pv;
        n_pidx        = r_pidx;
        n_commas      = r_commas;
        n_lastc       = r_lastc;
        n_field       = r_field;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_char_out    = r_char_out;
        n_field_index = r_field_index;
        n_field_end   = r_field_end;
        n_last        = r_last;
        n_overflow    = r_overflow;
        case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    if (full) begin
                        n_fill   = '0;
                        n_seen   = 1'b0;
                        n_base   = '0;
                        n_commas = '0;
                    end else begin
                        n_fill = fill_inc;
                        if (r_seen) begin
                            if (i_rx_byte == COMMA_CHAR) begin
                                n_commas = r_commas + FW'(1);
                                n_lastc  = r_fill[AW-1:0];
                            end
                        end else if (!below_window) begin
                            n_idx    = '0;
                            n_pv     = 1'b0;
                            n_commas = '0;
                            if (len_eff == 4'd0) begin
                                n_seen = 1'b1;
                            end
                        end
                    end
                end
            end
            S_OVF: begin
                if (slot_free) begin
                    n_out_valid   = 1'b1;
                    n_char_out    = '0;
                    n_field_index = '0;
                    n_field_end   = 1'b0;
                    n_last        = 1'b0;
                    n_overflow    = 1'b1;
                end
            end
            S_SRCH: begin
                n_pv   = issue;
                n_pidx = r_idx[AW-1:0];
                if (issue) begin
                    n_idx = r_idx + FW'(1);
                end
                if (hit) begin
                    n_base   = pos;
                    n_fill   = r_fill - FW'(pos);
                    n_seen   = 1'b1;
                    n_idx    = '0;
                    n_pv     = 1'b0;
                    n_commas = '0;
                end else if (stream_end) begin
                    n_fill = '0;
                end
            end
            S_SCAN: begin
                n_pv   = issue;
                n_pidx = r_idx[AW-1:0];
                if (issue) begin
                    n_idx = r_idx + FW'(1);
                end
                if (r_pv && rd_comma) begin
                    n_commas = r_commas + FW'(1);
                    n_lastc  = r_pidx;
                end
            end
            S_CHECK: begin
                n_idx   = '0;
                n_field = '0;
                if (emit_go && (r_commas == '0)) begin
                    n_fill   = '0;
                    n_seen   = 1'b0;
                    n_base   = '0;
                    n_commas = '0;
                end
            end
            S_EMIT_RD: begin
            end
            S_EMIT_OUT: begin
                if (slot_free) begin
                    n_out_valid   = 1'b1;
                    n_char_out    = rd_data;
                    n_field_index = r_field;
                    n_field_end   = rd_comma;
                    n_last        = at_last;
                    n_overflow    = 1'b0;
                    n_field       = r_field + 6'(rd_comma);
                    n_idx         = r_idx + FW'(1);
                    if (at_last) begin
                        n_fill   = '0;
                        n_seen   = 1'b0;
                        n_base   = '0;
                        n_commas = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_seen      <= 1'b0;
            r_base      <= '0;
            r_pv        <= 1'b0;
            r_commas    <= '0;
            r_out_valid <= 1'b0;
            r_hdr_chars <= HDR_CHARS_RST;
            r_hdr_len   <= HDR_LEN_RST;
            r_field_cnt <= FIELD_CNT_RST;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_seen      <= n_seen;
            r_base      <= n_base;
            r_pv        <= n_pv;
            r_commas    <= n_commas;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HDR_CHARS: r_hdr_chars <= i_cfg_data;
                    CFG_HDR_LEN:   r_hdr_len   <= i_cfg_data[3:0];
                    CFG_FIELD_CNT: r_field_cnt <= i_cfg_data[5:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_pidx        <= n_pidx;
        r_lastc       <= n_lastc;
        r_field       <= n_field;
        r_char_out    <= n_char_out;
        r_field_index <= n_field_index;
        r_field_end   <= n_field_end;
        r_last        <= n_last;
        r_overflow    <= n_overflow;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_char_out    = r_char_out;
    assign o_field_index = r_field_index;
    assign o_field_end   = r_field_end;
    assign o_last        = r_last;
    assign o_overflow    = r_overflow;

endmodule

`default_nettype wire

// File: test/nhfs_checker.sv
// Checker for the NMEA header field splitter: watches the input, output and
// register channels, predicts every output word and compares it field by field.
// Depends on nhfs_pkg for the comma code, register indexes and reset values.
`timescale 1ns / 1ps

module nhfs_checker
    import nhfs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  i_char_out,
    input  wire logic [5:0]  i_field_index,
    input  wire logic        i_field_end,
    input  wire logic        i_last,
    input  wire logic        i_overflow,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    output int               o_mismatches,
    output int               o_words_due,
    output int               o_fill,
    output logic             o_hdr_seen
);

    typedef struct packed {
        logic [7:0] chr;
        logic [5:0] field_idx;
        logic       field_end;
        logic       last;
        logic       overflow;
    } t_split_word;

    t_split_word due_words [$];

    logic [7:0]  line_buf [BUFFER_DEPTH_DEF];
    int          fill = 0;
    bit          hdr_seen = 1'b0;
    logic [63:0] hdr_chars = HDR_CHARS_RST;
    logic [3:0]  hdr_len = HDR_LEN_RST;
    logic [5:0]  fld_cnt = FIELD_CNT_RST;
    int          mismatches = 0;

    function automatic int find_header();
        int span;
        int p;
        int i;
        bit hit;
        span = (hdr_len > HDR_MAX_LEN) ? HDR_MAX_LEN : hdr_len;
        for (p = 0; p + span <= fill; p++) begin
            hit = 1'b1;
            for (i = 0; i < span; i++) begin
                if (line_buf[p + i] != hdr_chars[8 * i +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                return p;
            end
        end
        return -1;
    endfunction

    // Takes one received byte and queues words or an overflow word it releases.
    task automatic absorb_rx(input logic [7:0] rx);
        t_split_word w;
        int pos;
        int i;
        int commas;
        int last_comma;
        int fld;
        if (fill >= BUFFER_DEPTH_DEF) begin
            fill = 0;
            hdr_seen = 1'b0;
            w = '0;
            w.overflow = 1'b1;
            due_words = {due_words, w};
            return;
        end
        line_buf[fill] = rx;
        fill++;
        if (!hdr_seen) begin
            if (fill < WINDOW_DEF) begin
                return;
            end
            pos = find_header();
            if (pos < 0) begin
                fill = 0;
                return;
            end
            for (i = 0; i < fill - pos; i++) begin
                line_buf[i] = line_buf[i + pos];
            end
            fill -= pos;
            hdr_seen = 1'b1;
        end
        commas = 0;
        last_comma = 0;
        for (i = 0; i < fill; i++) begin
            if (line_buf[i] == COMMA_CHAR) begin
                commas++;
                last_comma = i;
            end
        end
        if (commas < fld_cnt) begin
            return;
        end
        if (commas > 0) begin
            fld = 0;
            for (i = 0; i <= last_comma; i++) begin
                w.chr = line_buf[i];
                w.field_idx = fld[5:0];
                w.field_end = (line_buf[i] == COMMA_CHAR);
                w.last = (i == last_comma);
                w.overflow = 1'b0;
                due_words = {due_words, w};
                if (w.field_end) begin
                    fld++;
                end
            end
        end
        fill = 0;
        hdr_seen = 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_word();
        t_split_word want;
        if (due_words.size() == 0) begin
            $error("output word with no prediction waiting: char_out 0x%0h", i_char_out);
            mismatches++;
        end else begin
            want = due_words.pop_front();
            compare_field("char_out", want.chr, i_char_out);
            compare_field("field_index", 8'(want.field_idx), 8'(i_field_index));
            compare_field("field_end", 8'(want.field_end), 8'(i_field_end));
            compare_field("last", 8'(want.last), 8'(i_last));
            compare_field("overflow", 8'(want.overflow), 8'(i_overflow));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill = 0;
            hdr_seen = 1'b0;
            hdr_chars = HDR_CHARS_RST;
            hdr_len = HDR_LEN_RST;
            fld_cnt = FIELD_CNT_RST;
            due_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_word();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HDR_CHARS: begin
                        hdr_chars = i_cfg_data;
                    end
                    CFG_HDR_LEN: begin
                        hdr_len = i_cfg_data[3:0];
                    end
                    CFG_FIELD_CNT: begin
                        fld_cnt = i_cfg_data[5:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                absorb_rx(i_rx_byte);
            end
        end
        o_mismatches <= mismatches;
        o_words_due <= due_words.size();
        o_fill <= fill;
        o_hdr_seen <= hdr_seen;
    end

endmodule

// File: test/tb_nmea_header_field_splitter_core.sv
// Testbench top for nmea_header_field_splitter_core: drives bytes, register
// writes and output back-pressure, and prints the verdict.
// Depends on nhfs_pkg, the block itself and the nhfs_checker module.
`timescale 1ns / 1ps

module tb_nmea_header_field_splitter_core;

    import nhfs_pkg::*;

    localparam logic [1:0]   CFG_SPARE      = 2'd3;
    localparam int           TOTAL_ITEMS    = 410;
    localparam int           SETTLE_CYCLES  = 200;
    localparam int           CYCLE_LIMIT    = 800000;
    localparam logic [63:0]  GGA_HDR        = 64'h0000_4147_4750_4724;
    localparam logic [63:0]  RMC_HDR        = 64'h0000_434D_5250_4724;
    localparam logic [127:0] GGA_LINE       = {8'h00, 8'hFF, "$GPGGA", ",1,", 8'h80,
                                               ",*7", 8'h0D};

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = CFG_HDR_CHARS;
    logic [63:0] i_cfg_data = 64'd0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_char_out;
    logic [5:0]  o_field_index;
    logic        o_field_end;
    logic        o_last;
    logic        o_overflow;
    logic        o_cfg_ready;

    int          mismatches;
    int          words_due;
    int          buf_fill;
    logic        buf_hdr_seen;

    int          sent_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 23;
    int          recv_idle_pct = 85;
    logic [63:0] cur_hdr = HDR_CHARS_RST;
    logic [3:0]  cur_len = HDR_LEN_RST;
    logic [5:0]  cur_fc = FIELD_CNT_RST;

    nmea_header_field_splitter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_char_out    (o_char_out),
        .o_field_index (o_field_index),
        .o_field_end   (o_field_end),
        .o_last        (o_last),
        .o_overflow    (o_overflow),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    nhfs_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_char_out    (o_char_out),
        .i_field_index (o_field_index),
        .i_field_end   (o_field_end),
        .i_last        (o_last),
        .i_overflow    (o_overflow),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_words_due   (words_due),
        .o_fill        (buf_fill),
        .o_hdr_seen    (buf_hdr_seen)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int hdr_span();
        return (cur_len > HDR_MAX_LEN) ? HDR_MAX_LEN : cur_len;
    endfunction

    function automatic logic [7:0] rand_text_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == COMMA_CHAR);
        return c;
    endfunction

    task automatic send_rx_byte(input logic [7:0] rx);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= rx;
        do begin
            @(posedge i_clk);
        end while (o_in_ready !== 1'b1);
        sent_count++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do begin
            @(posedge i_clk);
        end while (o_cfg_ready !== 1'b1);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_due != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [63:0] hdr, input logic [3:0] len,
                                 input logic [5:0] fc, input bit poke_spare);
        drain();
        if (poke_spare) begin
            write_reg(CFG_SPARE, {$urandom, $urandom});
        end
        write_reg(CFG_HDR_CHARS, hdr);
        write_reg(CFG_HDR_LEN, {60'd0, len});
        write_reg(CFG_FIELD_CNT, {58'd0, fc});
        i_cfg_valid <= 1'b0;
        cur_hdr = hdr;
        cur_len = len;
        cur_fc = fc;
    endtask

    // Places the header so that it lies inside the next search window. With
    // at_end set, only its first characters close the window, so it is missed.
    task automatic send_header_lead(input bit at_end);
        int span;
        int fill_now;
        int lead;
        int cut;
        int i;
        bit clip;
        span = hdr_span();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        fill_now = buf_fill;
        clip = at_end && !buf_hdr_seen && (span >= 2);
        lead = 0;
        if (!buf_hdr_seen) begin
            if (fill_now + span > WINDOW_DEF) begin
                repeat (WINDOW_DEF - fill_now) send_rx_byte(8'($urandom_range(0, 255)));
                fill_now = 0;
            end
            if (clip) begin
                lead = WINDOW_DEF - fill_now - span + 1;
            end else begin
                lead = $urandom_range(0, WINDOW_DEF - fill_now - span);
            end
        end
        repeat (lead) send_rx_byte(8'($urandom_range(0, 255)));
        cut = clip ? span - 1 : span;
        for (i = 0; i < cut; i++) begin
            send_rx_byte(cur_hdr[8 * i +: 8]);
        end
    endtask

    task automatic send_sentence(input bit truncate);
        int n_commas;
        int cut;
        int max_text;
        send_header_lead(1'b0);
        n_commas = (cur_fc == 0) ? $urandom_range(0, 3) : cur_fc;
        cut = (truncate && n_commas > 0) ? $urandom_range(0, n_commas - 1) : n_commas;
        max_text = (cur_fc > 40) ? 0 : (cur_fc > 16) ? 1 : 5;
        repeat (cut) begin
            repeat ($urandom_range(0, max_text)) send_rx_byte(rand_text_char());
            send_rx_byte(COMMA_CHAR);
        end
        repeat ($urandom_range(0, 3)) send_rx_byte(rand_text_char());
    endtask

    task automatic send_overflow_run();
        send_header_lead(1'b0);
        repeat (BUFFER_DEPTH_DEF) send_rx_byte(rand_text_char());
    endtask

    task automatic run_random_phase(input int n_items);
        int stop_at;
        int pick;
        int mode;
        stop_at = sent_count + n_items;
        while (sent_count < stop_at) begin
            mode = (sent_count * 3) / TOTAL_ITEMS;
            send_idle_pct = (mode == 0) ? 23 : (mode == 1) ? 85 : 0;
            recv_idle_pct = (mode == 0) ? 85 : (mode == 1) ? 23 : 0;
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                send_sentence(1'b0);
            end else if (pick < 80) begin
                send_sentence(1'b1);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 20)) send_rx_byte(8'($urandom_range(0, 255)));
            end else if (pick < 96) begin
                send_header_lead(1'b1);
            end else begin
                send_overflow_run();
            end
        end
    endtask

    initial begin
        int i;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_settings(GGA_HDR, 4'd6, 6'd3, 1'b0);
        for (i = 15; i >= 0; i--) begin
            send_rx_byte(GGA_LINE[8 * i +: 8]);
        end

        load_settings(RMC_HDR, 4'd6, FIELD_CNT_RST, 1'b0);
        send_overflow_run();
        run_random_phase(30);
        load_settings({$urandom, $urandom}, 4'd1, 6'd1, 1'b0);
        run_random_phase(25);
        load_settings(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 6'd20, 1'b1);
        run_random_phase(25);
        load_settings({$urandom, $urandom}, 4'd0, 6'd0, 1'b0);
        run_random_phase(25);
        load_settings({$urandom, $urandom}, 4'd13, 6'($urandom_range(1, 8)), 1'b0);
        run_random_phase(25);
        load_settings({$urandom, $urandom}, 4'd1, 6'd63, 1'b0);
        run_random_phase(10);
        load_settings({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                      6'($urandom_range(0, 63)), 1'b0);
        run_random_phase(25);
        drain();

        if (mismatches == 0 && words_due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/nhfs_pkg.sv
sv/nhfs_buf.sv
sv/nhfs_match.sv
sv/nmea_header_field_splitter_core.sv
test/nhfs_checker.sv
test/tb_nmea_header_field_splitter_core.sv
